[hw/rtl/bdc_pkg.sv]
// ----------------------------------------------------------------------------
// bdc_pkg - shared types and constants of the binary / DPD codec
// Operation codes, range limits and the stage records passed between the
// pipeline stages.
// ----------------------------------------------------------------------------
package bdc_pkg;

  // declets handled by the codec
  localparam int unsigned DeclCount = 4;
  // declets that fit in the 40-bit operand word
  localparam int unsigned HwGroups  = 4;
  // declets that carry data
  localparam int unsigned ActGroups = (DeclCount < HwGroups) ? DeclCount : HwGroups;

  // 1000 to the power n, elaboration time only
  function automatic logic [63:0] pow1000(int unsigned n);
    logic [63:0] acc;
    acc = 64'd1;
    for (int unsigned g = 0; g < n; g++) begin
      acc = acc * 64'd1000;
    end
    return acc;
  endfunction

  localparam logic [63:0] ValueMax   = 64'd2147483647;
  localparam logic [63:0] GroupCapM1 = pow1000(DeclCount) - 64'd1;
  localparam logic [63:0] EncLimit64 = (GroupCapM1 < ValueMax) ? GroupCapM1 : ValueMax;
  // largest value that encode accepts
  localparam logic [39:0] EncLimit   = EncLimit64[39:0];
  // decode saturation value
  localparam logic [39:0] SatValue   = ValueMax[39:0];
  // declet count reported on decode
  localparam logic [2:0]  DecCount   = 3'(DeclCount);

  typedef enum logic {
    OpEncode = 1'b0,
    OpDecode = 1'b1
  } op_e;

  // after stage 1: quotients for encode, unpacked groups for decode
  typedef struct packed {
    op_e                         op;
    logic                        err;
    logic [30:0]                 bin;
    logic [21:0]                 q1;   // bin / 10^3
    logic [11:0]                 q2;   // bin / 10^6
    logic [1:0]                  q3;   // bin / 10^9
    logic [HwGroups-1:0][9:0]    dec_grp;
  } s1_t;

  // after stage 2: three-digit groups for encode, binary sum for decode
  typedef struct packed {
    op_e                         op;
    logic                        err;
    logic [HwGroups-1:0][9:0]    enc_grp;
    logic [2:0]                  cnt;
    logic [39:0]                 dec_sum;
  } s2_t;

endpackage

[hw/rtl/binary_dpd_codec.sv]
// ----------------------------------------------------------------------------
// binary_dpd_codec - binary / densely packed decimal converter
// Encodes a binary integer into four declets or decodes four declets into
// a binary integer.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low;
//   busy stays low, so one transaction can be issued every cycle.
//   operation_i selects encode (0) or decode (1); operand_value_i carries
//   the binary number or the packed declets, lowest group in bits 9:0.
//   Each result is shown for one cycle with done_o high. done_o rises once
//   the transaction has passed the input register and the split, merge and
//   pack stage registers; results come out in issue order.
//   Throughput is one transaction per cycle, set by the four register
//   stages: input register, reciprocal dividers / declet unpack, group
//   remainders / weighted sum, and digit split / declet pack.
//   Encode values above the limit give 0, one declet and range_error_o;
//   decode results above 2147483647 saturate and flag range_error_o.
//   Reset clears all valid flags; work in flight is dropped. The receiver
//   cannot stall, so no backpressure path exists.
// ----------------------------------------------------------------------------
module binary_dpd_codec import bdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [39:0] operand_value_i,
  output logic        done_o,
  output logic [39:0] result_value_o,
  output logic [2:0]  declet_count_o,
  output logic        range_error_o
);

  logic        accept;
  logic        in_valid_q;
  op_e         op_q;
  logic [39:0] operand_q;
  logic        s1_valid;
  s1_t         s1_stage;
  logic        s2_valid;
  s2_t         s2_stage;

  // fully pipelined, never busy
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // input register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  // input register: payload
  always_ff @(posedge clk_i) begin
    op_q      <= op_e'(operation_i);
    operand_q <= operand_value_i;
  end

  bdc_split u_split (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_q),
    .op_i      (op_q),
    .operand_i (operand_q),
    .valid_o   (s1_valid),
    .stage_o   (s1_stage)
  );

  bdc_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .stage_i (s1_stage),
    .valid_o (s2_valid),
    .stage_o (s2_stage)
  );

  bdc_pack u_pack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (s2_valid),
    .stage_i        (s2_stage),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .declet_count_o (declet_count_o),
    .range_error_o  (range_error_o)
  );

  // every result strobe traces back to an accepted transaction
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 4))
    else $error("result strobe without a matching transaction");

  // an error gives either the encode reject pattern or decode saturation
  a_error_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && range_error_o) |->
      ((result_value_o == '0 && declet_count_o == 3'd1) ||
       (result_value_o == SatValue && declet_count_o == DecCount)))
    else $error("range error with unexpected result");

  // declet count stays within the codec width
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (declet_count_o != 3'd0 && declet_count_o <= DecCount))
    else $error("declet count out of range");

endmodule

[hw/rtl/bdc_split.sv]
// ----------------------------------------------------------------------------
// bdc_split - first pipeline stage of the codec
// Encode: range check and reciprocal division by 10^3, 10^6 and 10^9.
// Decode: unpacks each declet into its three-digit group value.
// ----------------------------------------------------------------------------
module bdc_split import bdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  op_e         op_i,
  input  logic [39:0] operand_i,
  output logic        valid_o,
  output s1_t         stage_o
);

  // reciprocals: floor(v / d) = (v * ceil(2^s / d)) >> s, exact for v < 2^31
  localparam logic [62:0] Recip3 = 63'd2199023256;  // s = 41
  localparam logic [62:0] Recip6 = 63'd2251799814;  // s = 51
  localparam logic [62:0] Recip9 = 63'd2305843010;  // s = 61

  // declet to group value (0..999), non-canonical codes included
  function automatic logic [9:0] decode_group(logic [9:0] dcl);
    logic p, q, r, s, t, u, v, w, x, y;
    logic a, b, c, d, e, f, g, h, i, j, k, m;
    logic [3:0] hd, td, ud;
    {p, q, r, s, t, u, v, w, x, y} = dcl;
    a = v & w & (~s | t | ~x);
    b = p & (~v | ~w | (s & ~t & x));
    c = q & (~v | ~w | (s & ~t & x));
    d = r;
    e = v & ((~w & x) | (~t & x) | (s & x));
    f = (s & (~v | ~x)) | (p & ~s & t & v & w & x);
    g = (t & (~v | ~x)) | (q & ~s & t & w);
    h = u;
    i = v & ((~w & ~x) | (w & x & (s | t)));
    j = (~v & w) | (s & v & ~w & x) | (p & w & (~x | (~s & ~t)));
    k = (~v & x) | (t & ~w & x) | (q & v & w & (~x | (~s & ~t)));
    m = y;
    hd = {a, b, c, d};
    td = {e, f, g, h};
    ud = {i, j, k, m};
    return 10'(hd) * 10'd100 + 10'(td) * 10'd10 + 10'(ud);
  endfunction

  logic        in_range;
  logic [30:0] bin;
  logic [62:0] prod3, prod6, prod9;
  s1_t         stage_d;
  logic        valid_q;
  s1_t         stage_q;

  // out-of-range encode operands are zeroed, which gives result 0, count 1
  assign in_range = (operand_i <= EncLimit);
  assign bin      = in_range ? operand_i[30:0] : '0;

  assign prod3 = 63'(bin) * Recip3;
  assign prod6 = 63'(bin) * Recip6;
  assign prod9 = 63'(bin) * Recip9;

  // stage record
  always_comb begin
    stage_d.op  = op_i;
    stage_d.err = (op_i == OpEncode) ? ~in_range : 1'b0;
    stage_d.bin = bin;
    stage_d.q1  = prod3[62:41];
    stage_d.q2  = prod6[62:51];
    stage_d.q3  = prod9[62:61];
    for (int unsigned gi = 0; gi < HwGroups; gi++) begin
      if (gi < ActGroups) begin
        stage_d.dec_grp[gi] = decode_group(operand_i[10*gi +: 10]);
      end else begin
        stage_d.dec_grp[gi] = '0;
      end
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

[hw/rtl/bdc_merge.sv]
// ----------------------------------------------------------------------------
// bdc_merge - second pipeline stage of the codec
// Encode: forms the base-1000 groups and the number of declets used.
// Decode: weights the group values into one binary sum.
// ----------------------------------------------------------------------------
module bdc_merge import bdc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  s1_t  stage_i,
  output logic valid_o,
  output s2_t  stage_o
);

  logic [31:0] rem0;
  logic [21:0] rem1;
  logic [11:0] rem2;
  s2_t         stage_d;
  logic        valid_q;
  s2_t         stage_q;

  // remainders of the successive quotients
  assign rem0 = {1'b0, stage_i.bin} - 32'(stage_i.q1) * 32'd1000;
  assign rem1 = stage_i.q1 - 22'(stage_i.q2) * 22'd1000;
  assign rem2 = stage_i.q2 - 12'(stage_i.q3) * 12'd1000;

  // stage record
  always_comb begin
    stage_d.op         = stage_i.op;
    stage_d.err        = stage_i.err;
    stage_d.enc_grp[0] = rem0[9:0];
    stage_d.enc_grp[1] = rem1[9:0];
    stage_d.enc_grp[2] = rem2[9:0];
    stage_d.enc_grp[3] = {8'b0, stage_i.q3};
    // highest nonzero group sets the count, zero still takes one declet
    stage_d.cnt = 3'd1;
    for (int unsigned gi = 1; gi < HwGroups; gi++) begin
      if (stage_d.enc_grp[gi] != '0) begin
        stage_d.cnt = 3'(gi + 1);
      end
    end
    stage_d.dec_sum = 40'(stage_i.dec_grp[3]) * 40'd1000000000
                    + 40'(stage_i.dec_grp[2]) * 40'd1000000
                    + 40'(stage_i.dec_grp[1]) * 40'd1000
                    + 40'(stage_i.dec_grp[0]);
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

[hw/rtl/bdc_pack.sv]
// ----------------------------------------------------------------------------
// bdc_pack - last pipeline stage and result register of the codec
// Encode: splits each group into BCD digits and packs the declets.
// Decode: saturates the binary sum.
// ----------------------------------------------------------------------------
module bdc_pack import bdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  s2_t         stage_i,
  output logic        done_o,
  output logic [39:0] result_value_o,
  output logic [2:0]  declet_count_o,
  output logic        range_error_o
);

  // group value (0..999) to declet
  function automatic logic [9:0] encode_group(logic [9:0] grp);
    logic [15:0] hp;
    logic [17:0] tp;
    logic [3:0]  hd;
    logic [6:0]  q10;
    logic [6:0]  tdw;
    logic [9:0]  udw;
    logic a, b, c, d, e, f, g, h, i, j, k, m;
    logic p, q, r, s, t, u, v, w, x, y;
    // x/100 = (x*41)>>12 and x/10 = (x*205)>>11 for x < 1000
    hp  = 16'(grp) * 16'd41;
    hd  = hp[15:12];
    tp  = 18'(grp) * 18'd205;
    q10 = tp[17:11];
    tdw = q10 - 7'(hd) * 7'd10;
    udw = grp - 10'(q10) * 10'd10;
    {a, b, c, d} = hd;
    {e, f, g, h} = tdw[3:0];
    {i, j, k, m} = udw[3:0];
    p = b | (a & j) | (a & f & i);
    q = c | (a & k) | (a & g & i);
    r = d;
    s = (f & (~a | ~i)) | (~a & e & j) | (e & i);
    t = g | (~a & e & k) | (a & i);
    u = h;
    v = a | e | i;
    w = a | (e & i) | (~e & j);
    x = e | (a & i) | (~a & k);
    y = m;
    return {p, q, r, s, t, u, v, w, x, y};
  endfunction

  logic [39:0] packed_w;
  logic        over;
  logic [39:0] result_d;
  logic [2:0]  count_d;
  logic        error_d;
  logic        done_q;
  logic [39:0] result_q;
  logic [2:0]  count_q;
  logic        error_q;

  // declet packing, lowest group lowest
  always_comb begin
    for (int unsigned gi = 0; gi < HwGroups; gi++) begin
      packed_w[10*gi +: 10] = encode_group(stage_i.enc_grp[gi]);
    end
  end

  assign over = (stage_i.dec_sum > SatValue);

  // result select
  always_comb begin
    case (stage_i.op)
      OpDecode: begin
        result_d = over ? SatValue : stage_i.dec_sum;
        count_d  = DecCount;
        error_d  = over;
      end
      default: begin
        result_d = packed_w;
        count_d  = stage_i.cnt;
        error_d  = stage_i.err;
      end
    endcase
  end

  // strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    count_q  <= count_d;
    error_q  <= error_d;
  end

  assign done_o         = done_q;
  assign result_value_o = result_q;
  assign declet_count_o = count_q;
  assign range_error_o  = error_q;

endmodule
